FILE: sv/lsps_pkg.sv
// shared types, register indexes, mode codes and arithmetic constants
// for the line sensor steering block; no dependencies
package lsps_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int INTEGRAL_WIDTH_DEF = 24;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_R = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_L = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT  = 3'd6;

  // drive modes
  localparam logic [1:0] MODE_FWD   = 2'd0;
  localparam logic [1:0] MODE_RIGHT = 2'd1;
  localparam logic [1:0] MODE_LEFT  = 2'd2;

  // sensor weights, sensor 0 first
  localparam logic signed [8:0] WEIGHT [SENSOR_COUNT] = '{
    -9'sd80, -9'sd50, -9'sd30, -9'sd10, 9'sd10, 9'sd30, 9'sd50, 9'sd80
  };

  // gains are held pre-scaled to 1/10000 units
  localparam int KP_W = 18;   // gain_p * 1000
  localparam int KD_W = 15;   // gain_d * 100
  localparam logic [KP_W-1:0] KP_SCALE = 18'd1000;
  localparam logic [KD_W-1:0] KD_SCALE = 15'd100;
  localparam logic [KP_W-1:0] KP_RESET = 18'd16000;
  localparam logic [KD_W-1:0] KD_RESET = 15'd1000;

  localparam int PTERM_W = 27;
  localparam int DTERM_W = 25;

  // correction magnitude: beyond this both wheels are pinned to the rails
  localparam int MAG_W = 23;
  localparam int MAG_LIMIT = 7680000;
  // exact divide by 10000 for any MAG_W bit value
  localparam int RECIP_SHIFT = 37;
  localparam int RECIP_W = 24;
  localparam logic [RECIP_W-1:0] RECIP_M = 24'd13743896;
  localparam int Q_W = 10;
  localparam int PROD_W = MAG_W + RECIP_W;

  typedef struct packed {
    logic                   invert;
    logic [KP_W-1:0]        kp;
    logic [7:0]             gain_i;
    logic [KD_W-1:0]        kd;
    logic [8:0]             base_r;
    logic [8:0]             base_l;
    logic [7:0]             pivot;
  } cfg_t;

  typedef struct packed {
    logic [1:0]             mode;
    logic                   sat;
    logic signed [8:0]      err;
    logic signed [9:0]      d;
    logic [7:0]             piv_r;
    logic [7:0]             piv_l;
  } trk_t;

  typedef struct packed {
    logic [1:0]             mode;
    logic                   sat;
    logic [7:0]             piv_r;
    logic [7:0]             piv_l;
    logic                   neg;
    logic [Q_W-1:0]         q;
  } corr_t;

endpackage

FILE: sv/line_sensor_pid_steering_top.sv
// a result beat passes the input, tracking, product, magnitude, divide and output registers
// throughput: one sample per cycle while the output is not stalled; every stage has its own
//   valid and a ready chained from all stages downstream, so bubbles fill while output stalls
// reset: synchronous active-low rst_n empties the pipeline, zeroes the
//   integral and previous error, and restores the default configuration
// depends on lsps_pkg, lsps_cfg, lsps_track, lsps_corr, lsps_drive
module line_sensor_pid_steering_top #(
  parameter int INTEGRAL_WIDTH = lsps_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // sample channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] sensor_bits
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [23:0]                      out_tdata,  // [7:0] speed_right,
                                                       // [15:8] speed_left,
                                                       // [16] integral_saturated,
                                                       // [23:17] zero
  output logic [1:0]                       out_tuser,  // [1:0] drive_mode
  // configuration writes
  input  logic                             cfg_we,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  lsps_pkg::cfg_t                   cfg;

  // tracking stage to correction pipe
  logic                             trk_valid, trk_ready;
  lsps_pkg::trk_t                   trk;
  logic signed [INTEGRAL_WIDTH-1:0] trk_acc;

  // correction pipe to output stage
  logic                             corr_valid, corr_ready;
  lsps_pkg::corr_t                  corr;

  logic [7:0]                       speed_r, speed_l;
  logic                             sat;

  // config registers, gains kept pre-scaled to 1/10000 units
  lsps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register, sensor decode, pivot test, integral and previous error
  lsps_track #(
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_bits   (in_tdata),
    .trk_valid (trk_valid),
    .trk_ready (trk_ready),
    .trk       (trk),
    .trk_acc   (trk_acc)
  );

  // products, then clamped magnitude, then reciprocal divide
  lsps_corr #(
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_corr (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .trk_valid  (trk_valid),
    .trk_ready  (trk_ready),
    .trk        (trk),
    .trk_acc    (trk_acc),
    .corr_valid (corr_valid),
    .corr_ready (corr_ready),
    .corr       (corr)
  );

  // wheel speeds and the output register
  lsps_drive u_drive (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .corr_valid  (corr_valid),
    .corr_ready  (corr_ready),
    .corr        (corr),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_mode    (out_tuser),
    .out_speed_r (speed_r),
    .out_speed_l (speed_l),
    .out_sat     (sat)
  );

  assign out_tdata = {7'd0, sat, speed_l, speed_r};

endmodule

FILE: sv/lsps_cfg.sv
// configuration register file with pre-scaled gains
// depends on lsps_pkg
module lsps_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output lsps_pkg::cfg_t                   cfg
);

  lsps_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invert <= 1'b0;
      cfg_r.kp     <= lsps_pkg::KP_RESET;
      cfg_r.gain_i <= 8'd1;
      cfg_r.kd     <= lsps_pkg::KD_RESET;
      cfg_r.base_r <= 9'd180;
      cfg_r.base_l <= 9'd180;
      cfg_r.pivot  <= 8'd180;
    end else if (cfg_we) begin
      case (cfg_index)
        lsps_pkg::REG_INVERT: cfg_r.invert <= cfg_wdata[0];
        lsps_pkg::REG_GAIN_P: cfg_r.kp <= lsps_pkg::KP_W'(cfg_wdata[7:0]) * lsps_pkg::KP_SCALE;
        lsps_pkg::REG_GAIN_I: cfg_r.gain_i <= cfg_wdata[7:0];
        lsps_pkg::REG_GAIN_D: cfg_r.kd <= lsps_pkg::KD_W'(cfg_wdata[7:0]) * lsps_pkg::KD_SCALE;
        lsps_pkg::REG_BASE_R: cfg_r.base_r <= cfg_wdata[8:0];
        lsps_pkg::REG_BASE_L: cfg_r.base_l <= cfg_wdata[8:0];
        lsps_pkg::REG_PIVOT:  cfg_r.pivot <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/lsps_track.sv
// input register, sensor decode, pivot decision and pid state update
// depends on lsps_pkg
module lsps_track #(
  parameter int INTEGRAL_WIDTH = lsps_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lsps_pkg::cfg_t                   cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lsps_pkg::SENSOR_COUNT-1:0] in_bits,
  output logic                             trk_valid,
  input  logic                             trk_ready,
  output lsps_pkg::trk_t                   trk,
  output logic signed [INTEGRAL_WIDTH-1:0] trk_acc
);

  localparam logic signed [INTEGRAL_WIDTH-1:0] IMAX = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
  localparam logic signed [INTEGRAL_WIDTH-1:0] IMIN = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};

  logic                              v0_r;
  logic [lsps_pkg::SENSOR_COUNT-1:0] bits0_r;
  logic                              v1_r;
  lsps_pkg::trk_t                    trk_r;
  logic signed [INTEGRAL_WIDTH-1:0]  acc1_r;
  logic signed [INTEGRAL_WIDTH-1:0]  integral_r;
  logic signed [8:0]                 prev_r;

  logic                              ready1;
  logic                              ld1;
  logic [lsps_pkg::SENSOR_COUNT-1:0] bits;
  logic [3:0]                        cnt;
  logic [4:0]                        sum;
  logic signed [8:0]                 err;
  logic [6:0]                        sum2, cnt5, cnt7, cnt11;
  logic                              go_right, go_left;
  logic signed [INTEGRAL_WIDTH:0]    acc_wide;
  logic                              ovf;
  logic signed [INTEGRAL_WIDTH-1:0]  acc_nxt;
  lsps_pkg::trk_t                    trk_nxt;

  assign ready1   = !v1_r || trk_ready;
  assign in_ready = !v0_r || ready1;
  assign ld1      = v0_r && ready1;

  // weighted error, active count and index sum
  always_comb begin
    bits = bits0_r ^ {lsps_pkg::SENSOR_COUNT{cfg.invert}};
    cnt = '0;
    sum = '0;
    err = '0;
    for (int i = 0; i < lsps_pkg::SENSOR_COUNT; i++) begin
      if (bits[i]) begin
        cnt = cnt + 4'd1;
        sum = sum + 5'(i);
        err = err + lsps_pkg::WEIGHT[i];
      end
    end
  end

  // centroid tests without division
  always_comb begin
    sum2  = {1'b0, sum, 1'b0};
    cnt5  = 7'(cnt) * 7'd5;
    cnt7  = 7'(cnt) * 7'd7;
    cnt11 = 7'(cnt) * 7'd11;
    go_right = ((cnt >= 4'd4) && (sum2 > cnt7)) || ((cnt >= 4'd3) && (sum2 >= cnt11));
    go_left  = !go_right &&
               (((cnt >= 4'd4) && (sum2 < cnt7)) || ((cnt >= 4'd3) && (sum2 <= cnt5)));
  end

  // saturating integral
  always_comb begin
    acc_wide = (INTEGRAL_WIDTH+1)'(integral_r) + (INTEGRAL_WIDTH+1)'(err);
    ovf      = acc_wide[INTEGRAL_WIDTH] != acc_wide[INTEGRAL_WIDTH-1];
    if (ovf) begin
      acc_nxt = acc_wide[INTEGRAL_WIDTH] ? IMIN : IMAX;
    end else begin
      acc_nxt = acc_wide[INTEGRAL_WIDTH-1:0];
    end
  end

  always_comb begin
    trk_nxt.err = err;
    trk_nxt.d   = 10'(err) - 10'(prev_r);
    if (go_right) begin
      trk_nxt.mode  = lsps_pkg::MODE_RIGHT;
      trk_nxt.sat   = 1'b0;
      trk_nxt.piv_r = {1'b0, cfg.pivot[7:1]};
      trk_nxt.piv_l = cfg.pivot;
    end else if (go_left) begin
      trk_nxt.mode  = lsps_pkg::MODE_LEFT;
      trk_nxt.sat   = 1'b0;
      trk_nxt.piv_r = cfg.pivot;
      trk_nxt.piv_l = {1'b0, cfg.pivot[7:1]};
    end else begin
      trk_nxt.mode  = lsps_pkg::MODE_FWD;
      trk_nxt.sat   = ovf;
      trk_nxt.piv_r = cfg.pivot;
      trk_nxt.piv_l = cfg.pivot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_ready) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      bits0_r <= in_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ready1) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      trk_r  <= trk_nxt;
      acc1_r <= acc_nxt;
    end
  end

  // pivot turns leave the pid state alone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      prev_r     <= '0;
    end else if (ld1 && (trk_nxt.mode == lsps_pkg::MODE_FWD)) begin
      integral_r <= acc_nxt;
      prev_r     <= err;
    end
  end

  assign trk_valid = v1_r;
  assign trk       = trk_r;
  assign trk_acc   = acc1_r;

`ifndef SYNTHESIS
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(ld1 && (trk_nxt.mode == lsps_pkg::MODE_FWD)) |=> ($stable(prev_r) && $stable(integral_r)))
    else $error("pid state moved without a forward beat");

  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (ld1 && trk_nxt.sat) |=> ((integral_r == IMAX) || (integral_r == IMIN)))
    else $error("saturation flagged but integral not at a rail");

  a_pivot_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && (trk_r.mode != lsps_pkg::MODE_FWD)) |-> !trk_r.sat)
    else $error("pivot beat carries saturation flag");
`endif

endmodule

FILE: sv/lsps_corr.sv
// pid correction: gain products, magnitude clamp, reciprocal divide by 10000
// depends on lsps_pkg
module lsps_corr #(
  parameter int INTEGRAL_WIDTH = lsps_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lsps_pkg::cfg_t                   cfg,
  input  logic                             trk_valid,
  output logic                             trk_ready,
  input  lsps_pkg::trk_t                   trk,
  input  logic signed [INTEGRAL_WIDTH-1:0] trk_acc,
  output logic                             corr_valid,
  input  logic                             corr_ready,
  output lsps_pkg::corr_t                  corr
);

  localparam int ITERM_W = INTEGRAL_WIDTH + 9;
  localparam int TOT_W = ((ITERM_W > lsps_pkg::PTERM_W) ? ITERM_W : lsps_pkg::PTERM_W) + 2;

  logic                                   v2_r, v3_r, v4_r;
  logic                                   ready2, ready3, ready4;
  lsps_pkg::trk_t                         trk2_r, trk3_r;
  logic signed [lsps_pkg::PTERM_W-1:0]    pt_r;
  logic signed [ITERM_W-1:0]              it_r;
  logic signed [lsps_pkg::DTERM_W-1:0]    dt_r;
  logic                                   neg3_r;
  logic [lsps_pkg::MAG_W-1:0]             mag3_r;
  lsps_pkg::corr_t                        corr4_r;

  logic signed [lsps_pkg::PTERM_W-1:0]    pt_nxt;
  logic signed [ITERM_W-1:0]              it_nxt;
  logic signed [lsps_pkg::DTERM_W-1:0]    dt_nxt;
  logic signed [TOT_W-1:0]                total;
  logic [TOT_W-1:0]                       mag_full;
  logic [lsps_pkg::MAG_W-1:0]             mag_nxt;
  logic [lsps_pkg::PROD_W-1:0]            prod;
  lsps_pkg::corr_t                        corr_nxt;

  assign ready4    = !v4_r || corr_ready;
  assign ready3    = !v3_r || ready4;
  assign ready2    = !v2_r || ready3;
  assign trk_ready = ready2;

  // one multiply per term
  always_comb begin
    pt_nxt = $signed({1'b0, cfg.kp}) * trk.err;
    it_nxt = $signed({1'b0, cfg.gain_i}) * trk_acc;
    dt_nxt = $signed({1'b0, cfg.kd}) * trk.d;
  end

  // sum, sign and magnitude; large magnitudes pin both wheels anyway
  always_comb begin
    total    = TOT_W'(pt_r) + TOT_W'(it_r) + TOT_W'(dt_r);
    mag_full = total[TOT_W-1] ? (~total + 1'b1) : total;
    if (mag_full >= TOT_W'(lsps_pkg::MAG_LIMIT)) begin
      mag_nxt = lsps_pkg::MAG_W'(lsps_pkg::MAG_LIMIT - 1);
    end else begin
      mag_nxt = mag_full[lsps_pkg::MAG_W-1:0];
    end
  end

  // truncating divide by 10000
  always_comb begin
    prod           = lsps_pkg::PROD_W'(mag3_r) * lsps_pkg::PROD_W'(lsps_pkg::RECIP_M);
    corr_nxt.mode  = trk3_r.mode;
    corr_nxt.sat   = trk3_r.sat;
    corr_nxt.piv_r = trk3_r.piv_r;
    corr_nxt.piv_l = trk3_r.piv_l;
    corr_nxt.neg   = neg3_r;
    corr_nxt.q     = prod[lsps_pkg::RECIP_SHIFT +: lsps_pkg::Q_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (ready2) v2_r <= trk_valid;
      if (ready3) v3_r <= v2_r;
      if (ready4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && trk_valid) begin
      trk2_r <= trk;
      pt_r   <= pt_nxt;
      it_r   <= it_nxt;
      dt_r   <= dt_nxt;
    end
    if (ready3 && v2_r) begin
      trk3_r <= trk2_r;
      neg3_r <= total[TOT_W-1];
      mag3_r <= mag_nxt;
    end
    if (ready4 && v3_r) begin
      corr4_r <= corr_nxt;
    end
  end

  assign corr_valid = v4_r;
  assign corr       = corr4_r;

endmodule

FILE: sv/lsps_drive.sv
// wheel speed selection and clamping into the output register
// depends on lsps_pkg
module lsps_drive (
  input  logic            clk,
  input  logic            rst_n,
  input  lsps_pkg::cfg_t  cfg,
  input  logic            corr_valid,
  output logic            corr_ready,
  input  lsps_pkg::corr_t corr,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_mode,
  output logic [7:0]      out_speed_r,
  output logic [7:0]      out_speed_l,
  output logic            out_sat
);

  logic              v_r;
  logic [1:0]        mode_r;
  logic [7:0]        sr_r, sl_r;
  logic              sat_r;

  logic signed [11:0] m;
  logic signed [11:0] a, b;
  logic [7:0]         sr_nxt, sl_nxt;

  assign corr_ready = !v_r || out_ready;

  always_comb begin
    m = corr.neg ? -12'(corr.q) : 12'(corr.q);
    a = $signed({3'b000, cfg.base_r}) - m;
    b = $signed({3'b000, cfg.base_l}) + m;
    if (corr.mode == lsps_pkg::MODE_FWD) begin
      sr_nxt = a[11] ? 8'd0 : ((a > 12'sd255) ? 8'd255 : a[7:0]);
      sl_nxt = b[11] ? 8'd0 : ((b > 12'sd255) ? 8'd255 : b[7:0]);
    end else begin
      sr_nxt = corr.piv_r;
      sl_nxt = corr.piv_l;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (corr_ready) begin
      v_r <= corr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (corr_ready && corr_valid) begin
      mode_r <= corr.mode;
      sr_r   <= sr_nxt;
      sl_r   <= sl_nxt;
      sat_r  <= corr.sat;
    end
  end

  assign out_valid   = v_r;
  assign out_mode    = mode_r;
  assign out_speed_r = sr_r;
  assign out_speed_l = sl_r;
  assign out_sat     = sat_r;

endmodule
